@@ rtl/core/fir_filter_41_tap_top_macros.svh @@
// Assertion macros used by the FIR filter top level.
`ifndef FIR_FILTER_41_TAP_TOP_MACROS_SVH
`define FIR_FILTER_41_TAP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FIR41_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FIR41_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FIR41_ASSERT(lbl, prop, msg)
`define FIR41_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ rtl/core/fir41_pkg.sv @@
// Constants and beat type for the FIR filter cell chain.
package fir41_pkg;

    localparam int TAPS     = 41;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 18;
    localparam int OUT_W    = 24;
    localparam int IDX_W    = 6;

    localparam int TAP_W  = ($clog2(TAPS) > IDX_W) ? $clog2(TAPS) : IDX_W;
    localparam int FILL_W = $clog2(TAPS + 1);
    localparam int SHIFT  = COEF_W - 2;
    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int RND_W  = PROD_W + 1 - SHIFT;
    localparam int ACC_W  = RND_W + $clog2(TAPS);
    localparam int EXT_W  = (ACC_W > OUT_W) ? ACC_W : OUT_W;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_LOAD   = 1'b1;

    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (SHIFT - 1);

    localparam logic [OUT_W-1:0] OUT_MAX_V = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN_V = {1'b1, {(OUT_W - 1){1'b0}}};
    localparam logic signed [EXT_W-1:0] OUT_MAX_X = EXT_W'($signed(OUT_MAX_V));
    localparam logic signed [EXT_W-1:0] OUT_MIN_X = EXT_W'($signed(OUT_MIN_V));

    typedef struct packed {
        logic                       valid;
        logic                       load;
        logic                       emit;
        logic                       last;
        logic [IDX_W-1:0]           idx;
        logic signed [COEF_W-1:0]   coef;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [ACC_W-1:0]    acc;
        logic signed [RND_W-1:0]    prod;
    } beat_t;

endpackage

@@ rtl/core/fir41_cell.sv @@
// One tap cell: holds a weight and a history sample, adds and multiplies in line.
module fir41_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic [fir41_pkg::TAP_W-1:0]   tap_id,
    input  fir41_pkg::beat_t              beat_in,
    output fir41_pkg::beat_t              beat_out
);
    import fir41_pkg::*;

    logic                       valid_reg;
    beat_t                      data_reg;
    beat_t                      data_next;
    logic signed [SAMPLE_W-1:0] hist_reg;
    logic signed [COEF_W-1:0]   weight_reg;

    logic signed [PROD_W-1:0]   prod_full;
    logic [PROD_W:0]            prod_bias;
    logic                       hit;

    assign hit = beat_in.valid && beat_in.load && (TAP_W'(beat_in.idx) == tap_id);

    always_comb
    begin
        prod_full = beat_in.sample * weight_reg;
        prod_bias = {prod_full[PROD_W-1], prod_full} + ROUND_HALF;
        data_next = beat_in;
        data_next.acc = beat_in.acc
                      + {{(ACC_W - RND_W){beat_in.prod[RND_W-1]}}, beat_in.prod};
        data_next.prod = prod_bias[PROD_W:SHIFT];
        // older sample moves on to the next cell
        data_next.sample = hist_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            hist_reg   <= '0;
            weight_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= beat_in.valid;
            if (beat_in.valid && !beat_in.load)
            begin
                hist_reg <= beat_in.sample;
            end
            if (hit)
            begin
                weight_reg <= beat_in.coef;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    always_comb
    begin
        beat_out = data_reg;
        beat_out.valid = valid_reg;
    end

endmodule

@@ rtl/core/fir41_tail.sv @@
// Final add, saturation and output register of the filter.
module fir41_tail (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  fir41_pkg::beat_t               beat_in,
    output logic                           out_valid,
    output logic [fir41_pkg::OUT_W-1:0]    filtered_value,
    output logic                           saturated,
    output logic                           last_out
);
    import fir41_pkg::*;

    logic signed [ACC_W-1:0] sum;
    logic signed [EXT_W-1:0] sum_x;
    logic                    over;
    logic                    under;
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        value_reg;
    logic [OUT_W-1:0]        value_next;
    logic                    sat_reg;
    logic                    last_reg;

    always_comb
    begin
        sum   = beat_in.acc
              + {{(ACC_W - RND_W){beat_in.prod[RND_W-1]}}, beat_in.prod};
        sum_x = EXT_W'(sum);
        over  = sum_x > OUT_MAX_X;
        under = sum_x < OUT_MIN_X;
        if (over)
        begin
            value_next = OUT_MAX_V;
        end
        else if (under)
        begin
            value_next = OUT_MIN_V;
        end
        else
        begin
            value_next = sum_x[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= beat_in.valid && !beat_in.load && beat_in.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg <= value_next;
            sat_reg   <= over || under;
            last_reg  <= beat_in.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_value = value_reg;
    assign saturated      = sat_reg;
    assign last_out       = last_reg;

endmodule

@@ rtl/core/fir_filter_41_tap_top.sv @@
// Top level of the streaming 41-tap FIR filter: fill tracking and the tap cell chain.
// Takes one beat per clock, sample or coefficient load alike, and holds it only while the
// output register is full and stalled. A beat crosses one tap cell per cycle while not
// stalled, so a result passes 41 cell stages plus the output stage after its sample is
// accepted, the first cell loading at the accepting edge; loads travel the same chain and
// apply at their cell in order with the samples around them.
// Results start once 41 samples have come in since reset or since a last-sample beat.
`include "fir_filter_41_tap_top_macros.svh"
module fir_filter_41_tap_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic signed [fir41_pkg::SAMPLE_W-1:0] sample_value,
    input  logic                             last_in,
    input  logic [fir41_pkg::IDX_W-1:0]      coef_index,
    input  logic signed [fir41_pkg::COEF_W-1:0]   coef_value,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [fir41_pkg::OUT_W-1:0]    filtered_value,
    output logic                             saturated,
    output logic                             last_out
);
    import fir41_pkg::*;

    logic              adv;
    logic              accept;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_inc;
    logic [FILL_W-1:0] fill_next;
    logic              emit;
    beat_t             chain [TAPS+1];

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign accept   = in_valid && adv;

    always_comb
    begin
        fill_inc  = (fill_reg == FILL_W'(TAPS)) ? fill_reg : fill_reg + FILL_W'(1);
        emit      = fill_inc == FILL_W'(TAPS);
        fill_next = last_in ? '0 : fill_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (accept && (action == ACT_SAMPLE))
        begin
            fill_reg <= fill_next;
        end
    end

    always_comb
    begin
        chain[0].valid  = accept;
        chain[0].load   = action == ACT_LOAD;
        chain[0].emit   = emit;
        chain[0].last   = last_in;
        chain[0].idx    = coef_index;
        chain[0].coef   = coef_value;
        chain[0].sample = sample_value;
        chain[0].acc    = '0;
        chain[0].prod   = '0;
    end

    // cell k serves tap TAPS-1-k: newest sample meets the first cell
    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        fir41_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .tap_id   (TAP_W'(TAPS - 1 - k)),
            .beat_in  (chain[k]),
            .beat_out (chain[k+1])
        );
    end

    fir41_tail u_tail (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (adv),
        .beat_in        (chain[TAPS]),
        .out_valid      (out_valid),
        .filtered_value (filtered_value),
        .saturated      (saturated),
        .last_out       (last_out)
    );

    `FIR41_ASSERT(a_fill_range, fill_reg <= FILL_W'(TAPS), "fill count beyond tap count")
    `FIR41_ASSERT_NEXT(a_last_clears, accept && (action == ACT_SAMPLE) && last_in, fill_reg == '0, "fill count not cleared by last sample")
    `FIR41_ASSERT_NEXT(a_load_keeps_fill, accept && (action == ACT_LOAD), $stable(fill_reg), "coefficient load moved fill count")
    `FIR41_ASSERT(a_sat_clamped, (out_valid && saturated) |-> (filtered_value == OUT_MAX_V || filtered_value == OUT_MIN_V), "saturated result not at a rail")

endmodule

@@ sim/fir_filter_41_tap_checker.sv @@
// Checker for the 41-tap FIR: predicts filter results from the input beats and compares outputs.
`timescale 1ns / 1ps

module fir_filter_41_tap_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  action,
    input  logic signed [fir41_pkg::SAMPLE_W-1:0] sample_value,
    input  logic                                  last_in,
    input  logic [fir41_pkg::IDX_W-1:0]           coef_index,
    input  logic signed [fir41_pkg::COEF_W-1:0]   coef_value,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [fir41_pkg::OUT_W-1:0]    filtered_value,
    input  logic                                  saturated,
    input  logic                                  last_out,
    output int                                    fail_count,
    output int                                    pending
);

    import fir41_pkg::*;

    localparam int  FRAC_SHIFT = COEF_W - 2;
    localparam longint SUM_MAX = (longint'(1) << (OUT_W - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic                    sat;
        logic                    last;
    } fir_result_t;

    logic signed [SAMPLE_W-1:0] sample_line [TAPS];
    logic signed [COEF_W-1:0]   tap_coef    [TAPS];
    int                         fill_level;
    fir_result_t                result_q [$];
    int                         mismatches;

    // Rounded products summed exactly, then clipped to the output range.
    function automatic fir_result_t filter_sum(input logic last);
        fir_result_t r;
        longint      acc;
        longint      prod;
        acc = 0;
        for (int i = 0; i < TAPS; i++)
        begin
            prod = longint'(sample_line[i]) * longint'(tap_coef[i])
                 + (longint'(1) << (FRAC_SHIFT - 1));
            acc += prod >>> FRAC_SHIFT;
        end
        r.sat = 1'b1;
        if (acc > SUM_MAX)
            acc = SUM_MAX;
        else if (acc < SUM_MIN)
            acc = SUM_MIN;
        else
            r.sat = 1'b0;
        r.value = OUT_W'(acc);
        r.last  = last;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fir_result_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                sample_line[i] = '0;
                tap_coef[i]    = '0;
            end
            fill_level = 0;
            mismatches = 0;
            result_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result beat value=%0d sat=%b last=%b",
                                 $realtime, filtered_value, saturated, last_out);
                    mismatches++;
                end
                else
                begin
                    exp_r = result_q.pop_front();
                    if (filtered_value !== exp_r.value || saturated !== exp_r.sat ||
                        last_out !== exp_r.last)
                    begin
                        if (mismatches < 10)
                            $display("%0t: mismatch exp value=%0d sat=%b last=%b, got value=%0d sat=%b last=%b",
                                     $realtime, exp_r.value, exp_r.sat, exp_r.last,
                                     filtered_value, saturated, last_out);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (action == ACT_LOAD)
                begin
                    if (coef_index < TAPS)
                        tap_coef[coef_index] = coef_value;
                end
                else
                begin
                    for (int i = 0; i < TAPS - 1; i++)
                        sample_line[i] = sample_line[i + 1];
                    sample_line[TAPS - 1] = sample_value;
                    if (fill_level < TAPS)
                        fill_level++;
                    if (fill_level == TAPS)
                        result_q.push_back(filter_sum(last_in));
                    if (last_in)
                        fill_level = 0;
                end
            end
            fail_count <= mismatches;
            pending    <= result_q.size();
        end
    end

endmodule

@@ sim/fir_filter_41_tap_top_tb.sv @@
// Testbench top for the 41-tap FIR: clock, reset, beat stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module fir_filter_41_tap_top_tb;

    import fir41_pkg::*;

    localparam int ITEM_TARGET    = 1300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_in;
    logic [IDX_W-1:0]           coef_index;
    logic signed [COEF_W-1:0]   coef_value;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [OUT_W-1:0]    filtered_value;
    logic                       saturated;
    logic                       last_out;

    int fail_count;
    int pending;
    int items_sent;
    int idle_cycles;
    bit src_fast;

    fir_filter_41_tap_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .sample_value   (sample_value),
        .last_in        (last_in),
        .coef_index     (coef_index),
        .coef_value     (coef_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filtered_value (filtered_value),
        .saturated      (saturated),
        .last_out       (last_out)
    );

    fir_filter_41_tap_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .sample_value   (sample_value),
        .last_in        (last_in),
        .coef_index     (coef_index),
        .coef_value     (coef_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filtered_value (filtered_value),
        .saturated      (saturated),
        .last_out       (last_out),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(SAMPLE_W - 1){1'b0}}};
            1: return {1'b0, {(SAMPLE_W - 1){1'b1}}};
            2: return '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(COEF_W - 1){1'b0}}};
            1: return {1'b0, {(COEF_W - 1){1'b1}}};
            2: return '0;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic act, input logic signed [SAMPLE_W-1:0] smp,
                             input logic lst, input logic [IDX_W-1:0] idx,
                             input logic signed [COEF_W-1:0] cf);
        int gap;
        gap = src_fast ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        sample_value <= smp;
        last_in      <= lst;
        coef_index   <= idx;
        coef_value   <= cf;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        if (act == ACT_SAMPLE || idx < TAPS)
            items_sent++;
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic lst);
        send_beat(ACT_SAMPLE, smp, lst, IDX_W'($urandom), COEF_W'($urandom));
    endtask

    task automatic send_load(input logic [IDX_W-1:0] idx, input logic signed [COEF_W-1:0] cf);
        send_beat(ACT_LOAD, SAMPLE_W'($urandom), 1'($urandom), idx, cf);
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(0, 9) == 0)
            return IDX_W'($urandom_range(TAPS, (1 << IDX_W) - 1));
        return IDX_W'($urandom_range(0, TAPS - 1));
    endfunction

    initial
    begin
        int stream_len;
        int n_loads;
        in_valid     = 1'b0;
        action       = ACT_SAMPLE;
        sample_value = '0;
        last_in      = 1'b0;
        coef_index   = '0;
        coef_value   = '0;
        rst_n        = 1'b0;
        items_sent   = 0;
        src_fast     = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: coefficient extremes, ignored indexes, short streams
        send_load(IDX_W'(0), {1'b1, {(COEF_W - 1){1'b0}}});
        send_load(IDX_W'(TAPS - 1), {1'b0, {(COEF_W - 1){1'b1}}});
        send_load(IDX_W'(TAPS), 18'sd5);
        send_load({IDX_W{1'b1}}, -18'sd1);
        send_load(IDX_W'(20), '0);
        send_sample({1'b1, {(SAMPLE_W - 1){1'b0}}}, 1'b0);
        send_sample({1'b0, {(SAMPLE_W - 1){1'b1}}}, 1'b0);
        send_sample('0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);
        send_sample({1'b0, {(SAMPLE_W - 1){1'b1}}}, 1'b1);
        for (int i = 0; i < TAPS; i++)
            send_sample({1'b1, {(SAMPLE_W - 1){1'b0}}}, i == TAPS - 1);

        while (items_sent < ITEM_TARGET)
        begin
            src_fast = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
            begin
                n_loads = $urandom_range(1, TAPS + 4);
                repeat (n_loads) send_load(pick_index(), pick_coef());
            end
            stream_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, TAPS - 1)
                                                     : $urandom_range(TAPS, 100);
            for (int i = 0; i < stream_len; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_load(pick_index(), pick_coef());
                send_sample(pick_sample(), i == stream_len - 1);
            end
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output side: random hold-off per result, with stall-free stretches
    initial
    begin
        int  hold;
        bit  sink_fast;
        sink_fast = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 29) == 0)
                sink_fast = ~sink_fast;
            hold = sink_fast ? 0 : $urandom_range(0, 18);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
